// ===== sv/bslm_pkg.sv =====
// Shared types and constants for the buffer slot LRU mapper.
package bslm_pkg;

    localparam int unsigned SLOT_COUNT_DEF = 32;
    localparam int unsigned IDENT_W        = 32;
    localparam int unsigned STAMP_W        = 64;
    localparam int unsigned SLOT_FIELD_W   = 5;

    typedef enum logic [1:0] {
        REQ_ASSIGN  = 2'd0,
        REQ_RELEASE = 2'd1,
        REQ_CLEAR   = 2'd2,
        REQ_UNUSED  = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_HIT      = 3'd0,
        ST_FREE     = 3'd1,
        ST_EVICT    = 3'd2,
        ST_RELEASED = 3'd3,
        ST_MISS     = 3'd4,
        ST_CLEARED  = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

endpackage

// ===== sv/buffer_slot_lru_mapper.sv =====
// Buffer slot mapper with least recently used replacement, scanned by one shared compare unit.
//
// Usage:
//   Requests enter on the s_axis channel: s_axis_tuser carries the request type
//   (assign, release, clear) and s_axis_tdata the buffer identifier. Each request
//   gives exactly one result on the m_axis channel: slot index and evicted
//   identifier in m_axis_tdata, status code in m_axis_tuser.
//   Assign and release walk every slot once through one owner compare and one
//   stamp compare, one slot per cycle out of the owner and stamp memories.
//   Clear and the unused request type skip the walk and go from idle straight
//   to the finish step.
//   s_axis_tready is high only while no request is in work; the next request is
//   taken even while the last result still waits in the output register.
//   Reset clears every busy bit, the stamp counter and the output valid; owner
//   and stamp memories are not cleared, and their values are used only for busy slots.
//   When the receiver stalls, the result holds in the output register; a
//   finished request waits in its last step until that register frees up.
module buffer_slot_lru_mapper
    import bslm_pkg::*;
#(
    parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [31:0] buffer_ident
    input  logic [31:0] s_axis_tdata,
    // [1:0] req_type
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [4:0] slot_index, [36:5] evicted_ident, [39:37] zero
    output logic [39:0] m_axis_tdata,
    // [2:0] status_code
    output logic [2:0]  m_axis_tuser
);

    localparam int unsigned IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int unsigned CW = $clog2(SLOT_COUNT + 1);
    localparam logic [CW-1:0] LAST_CNT = CW'(SLOT_COUNT);

    // slot state: busy bits in flops, owner and stamp in memories
    logic [SLOT_COUNT-1:0] r_busy;
    logic [IDENT_W-1:0]    mem_owner [SLOT_COUNT];
    logic [STAMP_W-1:0]    mem_stamp [SLOT_COUNT];
    logic [STAMP_W-1:0]    r_stamp_cnt;

    t_state r_state, n_state;

    // captured request
    t_req               r_req;
    logic [IDENT_W-1:0] r_ident;

    // walk control
    logic [CW-1:0] r_rd_cnt;
    logic          rd_issue;
    logic [IW-1:0] rd_addr;
    logic          r_cmp_vld;
    logic [IW-1:0] r_cmp_idx;
    logic          r_cmp_busy;
    logic [IDENT_W-1:0] r_cmp_owner;
    logic [STAMP_W-1:0] r_cmp_stamp;

    // walk results
    logic               r_hit;
    logic [IW-1:0]      r_hit_idx;
    logic               r_free;
    logic [IW-1:0]      r_free_idx;
    logic [IW-1:0]      r_old_idx;
    logic [IDENT_W-1:0] r_old_owner;
    logic [STAMP_W-1:0] r_old_stamp;

    // output register
    logic               r_out_vld;
    logic [IW-1:0]      r_out_slot;
    t_status            r_out_status;
    logic [IDENT_W-1:0] r_out_evict;

    // finish-step decisions
    logic               out_free;
    logic               fin_load;
    logic [IW-1:0]      fin_slot;
    t_status            fin_status;
    logic [IDENT_W-1:0] fin_evict;
    logic               fin_wr_owner;
    logic               fin_wr_stamp;
    logic               fin_set_busy;
    logic               fin_clr_busy;
    logic               fin_clear_all;
    logic               fin_bump;
    logic [STAMP_W-1:0] stamp_next;
    logic [IW+SLOT_FIELD_W-1:0] slot_ext;

    assign out_free   = !r_out_vld || m_axis_tready;
    assign rd_issue   = (r_state == S_SCAN) && (r_rd_cnt != LAST_CNT);
    assign rd_addr    = r_rd_cnt[IW-1:0];
    assign stamp_next = r_stamp_cnt + STAMP_W'(1);

    // next state and finish-step decode
    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        fin_load      = 1'b0;
        fin_slot      = '0;
        fin_status    = ST_MISS;
        fin_evict     = '0;
        fin_wr_owner  = 1'b0;
        fin_wr_stamp  = 1'b0;
        fin_set_busy  = 1'b0;
        fin_clr_busy  = 1'b0;
        fin_clear_all = 1'b0;
        fin_bump      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    if (t_req'(s_axis_tuser) == REQ_ASSIGN
                        || t_req'(s_axis_tuser) == REQ_RELEASE) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_SCAN: begin
                // walk is done once every read has issued and the last one compared
                if (!rd_issue && !r_cmp_vld) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                unique case (r_req)
                    REQ_ASSIGN: begin
                        fin_wr_stamp = 1'b1;
                        fin_bump     = 1'b1;
                        priority if (r_hit) begin
                            fin_slot   = r_hit_idx;
                            fin_status = ST_HIT;
                        end else if (r_free) begin
                            fin_slot     = r_free_idx;
                            fin_status   = ST_FREE;
                            fin_wr_owner = 1'b1;
                            fin_set_busy = 1'b1;
                        end else begin
                            fin_slot     = r_old_idx;
                            fin_status   = ST_EVICT;
                            fin_evict    = r_old_owner;
                            fin_wr_owner = 1'b1;
                            fin_set_busy = 1'b1;
                        end
                    end
                    REQ_RELEASE: begin
                        if (r_hit) begin
                            fin_slot     = r_hit_idx;
                            fin_status   = ST_RELEASED;
                            fin_clr_busy = 1'b1;
                        end
                    end
                    REQ_CLEAR: begin
                        fin_status    = ST_CLEARED;
                        fin_clear_all = 1'b1;
                    end
                    REQ_UNUSED: begin
                        fin_status = ST_MISS;
                    end
                    default: begin
                        fin_status = ST_MISS;
                    end
                endcase
                if (out_free) begin
                    fin_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control: busy bits, stamp counter, walk sequencing, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= '0;
            r_stamp_cnt <= '0;
            r_rd_cnt    <= '0;
            r_cmp_vld   <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_cmp_vld <= rd_issue;
            if (r_state == S_IDLE) begin
                r_rd_cnt <= '0;
            end else if (rd_issue) begin
                r_rd_cnt <= r_rd_cnt + CW'(1);
            end
            // commit only when the result is taken into the output register
            if (fin_load) begin
                if (fin_clear_all) begin
                    r_busy      <= '0;
                    r_stamp_cnt <= '0;
                end else begin
                    if (fin_set_busy) begin
                        r_busy[fin_slot] <= 1'b1;
                    end
                    if (fin_clr_busy) begin
                        r_busy[fin_slot] <= 1'b0;
                    end
                    if (fin_bump) begin
                        r_stamp_cnt <= stamp_next;
                    end
                end
            end
            if (fin_load) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // owner and stamp memories: one registered read, one write
    always_ff @(posedge i_clk) begin
        if (rd_issue) begin
            r_cmp_owner <= mem_owner[rd_addr];
            r_cmp_stamp <= mem_stamp[rd_addr];
        end
        if (fin_load && fin_wr_owner) begin
            mem_owner[fin_slot] <= r_ident;
        end
        if (fin_load && fin_wr_stamp) begin
            mem_stamp[fin_slot] <= stamp_next;
        end
    end

    // shared compare unit: one slot per cycle against request and running oldest
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && s_axis_tvalid) begin
            r_req   <= t_req'(s_axis_tuser);
            r_ident <= s_axis_tdata;
            r_hit   <= 1'b0;
            r_free  <= 1'b0;
        end
        if (rd_issue) begin
            r_cmp_idx  <= rd_addr;
            r_cmp_busy <= r_busy[rd_addr];
        end
        if (r_cmp_vld) begin
            if (r_cmp_busy && !r_hit && r_cmp_owner == r_ident) begin
                r_hit     <= 1'b1;
                r_hit_idx <= r_cmp_idx;
            end
            if (!r_cmp_busy && !r_free) begin
                r_free     <= 1'b1;
                r_free_idx <= r_cmp_idx;
            end
            // strict less keeps the lowest slot on equal stamps
            if (r_cmp_idx == '0 || r_cmp_stamp < r_old_stamp) begin
                r_old_idx   <= r_cmp_idx;
                r_old_owner <= r_cmp_owner;
                r_old_stamp <= r_cmp_stamp;
            end
        end
        if (fin_load) begin
            r_out_slot   <= fin_slot;
            r_out_status <= fin_status;
            r_out_evict  <= fin_evict;
        end
    end

    // report the low bits of the slot number
    assign slot_ext      = {{SLOT_FIELD_W{1'b0}}, r_out_slot};
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {3'b000, r_out_evict, slot_ext[SLOT_FIELD_W-1:0]};
    assign m_axis_tuser  = r_out_status;

endmodule

// ===== bench/tb_buffer_slot_lru_mapper.sv =====
// Self-checking testbench for the buffer slot LRU mapper: directed table, then random requests.
module tb_buffer_slot_lru_mapper;
    import bslm_pkg::*;

    // One result as it leaves the block on the m_axis side.
    typedef struct packed {
        logic [4:0]  slot;
        t_status     status;
        logic [31:0] evicted;
    } t_slot_result;

    // One row of the directed table; typed rows carry a hand-written result.
    typedef struct packed {
        t_req         req;
        logic [31:0]  ident;
        logic         typed;
        t_slot_result want;
    } t_directed_row;

    localparam int DIRECTED_ROWS = 15;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 250;
    localparam int CALM_PHASES   = 2;
    localparam int TAIL_CYCLES   = 50;

    // Walk the corners first: release on an empty map, the extreme identifiers,
    // a hit, a release that frees a slot below others, the unused request type,
    // a clear, and a reuse of slot 0 after the clear.
    localparam t_directed_row DIRECTED [DIRECTED_ROWS] = '{
        '{REQ_RELEASE, 32'h0000_0000, 1'b1, '{5'd0, ST_MISS,     32'd0}},
        '{REQ_ASSIGN,  32'h0000_0000, 1'b1, '{5'd0, ST_FREE,     32'd0}},
        '{REQ_ASSIGN,  32'hFFFF_FFFF, 1'b1, '{5'd1, ST_FREE,     32'd0}},
        '{REQ_ASSIGN,  32'h8000_0000, 1'b0, '{5'd0, ST_HIT,      32'd0}},
        '{REQ_ASSIGN,  32'h7FFF_FFFF, 1'b0, '{5'd0, ST_HIT,      32'd0}},
        '{REQ_ASSIGN,  32'h0000_0000, 1'b0, '{5'd0, ST_HIT,      32'd0}},
        '{REQ_RELEASE, 32'hFFFF_FFFF, 1'b0, '{5'd0, ST_HIT,      32'd0}},
        '{REQ_ASSIGN,  32'h1234_5678, 1'b0, '{5'd0, ST_HIT,      32'd0}},
        '{REQ_UNUSED,  32'hFFFF_FFFF, 1'b1, '{5'd0, ST_MISS,     32'd0}},
        '{REQ_RELEASE, 32'h1234_5678, 1'b0, '{5'd0, ST_HIT,      32'd0}},
        '{REQ_RELEASE, 32'hFFFF_FFFF, 1'b1, '{5'd0, ST_MISS,     32'd0}},
        '{REQ_CLEAR,   32'hA5A5_A5A5, 1'b1, '{5'd0, ST_CLEARED,  32'd0}},
        '{REQ_RELEASE, 32'h8000_0000, 1'b1, '{5'd0, ST_MISS,     32'd0}},
        '{REQ_ASSIGN,  32'h8000_0000, 1'b1, '{5'd0, ST_FREE,     32'd0}},
        '{REQ_ASSIGN,  32'h7FFF_FFFF, 1'b1, '{5'd1, ST_FREE,     32'd0}}
    };

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [31:0] buffer_ident
    logic [31:0] s_axis_tdata  = '0;
    // [1:0] req_type
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [4:0] slot_index, [36:5] evicted_ident, [39:37] zero
    logic [39:0] m_axis_tdata;
    // [2:0] status_code
    logic [2:0]  m_axis_tuser;

    // Shadow copy of the slot map, kept in step with accepted requests.
    logic        map_busy  [SLOT_COUNT_DEF];
    logic [31:0] map_owner [SLOT_COUNT_DEF];
    logic [63:0] map_stamp [SLOT_COUNT_DEF];
    logic [63:0] map_clock;

    t_slot_result pending_results [$];
    int           fail_count    = 0;
    logic         stall_enable  = 1'b1;
    int           stall_left    = 0;

    buffer_slot_lru_mapper uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop: far beyond the slowest legal run.
    initial begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Return the busy slot that holds the identifier, or -1 when none does.
    function automatic int holder_of(input logic [31:0] ident);
        int found;
        found = -1;
        for (int i = SLOT_COUNT_DEF - 1; i >= 0; i--) begin
            if (map_busy[i] && map_owner[i] == ident) begin
                found = i;
            end
        end
        return found;
    endfunction

    // Apply one request to the shadow map and return the slot result it gives.
    function automatic t_slot_result compute_slot_result(input t_req req,
                                                         input logic [31:0] ident);
        t_slot_result res;
        int           hit;
        int           pick;
        res  = '{slot: 5'd0, status: ST_MISS, evicted: 32'd0};
        pick = -1;
        case (req)
            REQ_ASSIGN: begin
                hit = holder_of(ident);
                if (hit >= 0) begin
                    // Refresh the stamp of the slot already holding the identifier.
                    map_clock      = map_clock + 64'd1;
                    map_stamp[hit] = map_clock;
                    res.slot       = 5'(hit);
                    res.status     = ST_HIT;
                end else begin
                    for (int i = SLOT_COUNT_DEF - 1; i >= 0; i--) begin
                        if (!map_busy[i]) begin
                            pick = i;
                        end
                    end
                    if (pick >= 0) begin
                        res.status = ST_FREE;
                    end else begin
                        // Evict the oldest stamp; a strict compare keeps the lowest slot on ties.
                        pick = 0;
                        for (int i = 1; i < SLOT_COUNT_DEF; i++) begin
                            if (map_stamp[i] < map_stamp[pick]) begin
                                pick = i;
                            end
                        end
                        res.status  = ST_EVICT;
                        res.evicted = map_owner[pick];
                    end
                    map_busy[pick]  = 1'b1;
                    map_owner[pick] = ident;
                    map_clock       = map_clock + 64'd1;
                    map_stamp[pick] = map_clock;
                    res.slot        = 5'(pick);
                end
            end
            REQ_RELEASE: begin
                hit = holder_of(ident);
                if (hit >= 0) begin
                    map_busy[hit] = 1'b0;
                    res.slot      = 5'(hit);
                    res.status    = ST_RELEASED;
                end
            end
            REQ_CLEAR: begin
                for (int i = 0; i < SLOT_COUNT_DEF; i++) begin
                    map_busy[i] = 1'b0;
                end
                map_clock  = 64'd0;
                res.status = ST_CLEARED;
            end
            default: begin
                // Unused request type: leave the map alone and report a miss.
            end
        endcase
        return res;
    endfunction

    // Present one request, hold it until the handshake, then queue its result.
    // A typed row queues the hand-written result instead of the predicted one.
    task automatic issue_request(input t_req req, input logic [31:0] ident,
                                 input logic typed, input t_slot_result want);
        t_slot_result predicted;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ident;
        s_axis_tuser  <= req;
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = compute_slot_result(req, ident);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // Drop valid and idle the sender for a burst of cycles.
    task automatic hold_sender(input int cycles);
        s_axis_tvalid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Drop valid and wait until every queued result has come back.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // Receiver: stall in random bursts while stalling is enabled; otherwise ready stays high.
    always @(posedge i_clk) begin
        if (!stall_enable) begin
            m_axis_tready <= 1'b1;
            stall_left    <= 0;
        end else if (stall_left != 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= $urandom_range(0, 14);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Check every accepted result against the oldest queued expectation.
    always @(posedge i_clk) begin
        t_slot_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing expected: tdata %h tuser %0d",
                         $time, m_axis_tdata, m_axis_tuser);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata[4:0] !== want.slot) begin
                    $display("%0t: slot_index expected %0d actual %0d",
                             $time, want.slot, m_axis_tdata[4:0]);
                    fail_count++;
                end
                if (m_axis_tuser !== want.status) begin
                    $display("%0t: status_code expected %0d actual %0d",
                             $time, want.status, m_axis_tuser);
                    fail_count++;
                end
                if (m_axis_tdata[36:5] !== want.evicted) begin
                    $display("%0t: evicted_ident expected %h actual %h",
                             $time, want.evicted, m_axis_tdata[36:5]);
                    fail_count++;
                end
            end
        end
    end

    // Stimulus: reset, directed table, then random phases over identifier pools.
    initial begin
        logic [31:0] pool [$];
        int          pool_size;
        int          roll;
        t_req        req;
        logic [31:0] ident;

        for (int i = 0; i < SLOT_COUNT_DEF; i++) begin
            map_busy[i]  = 1'b0;
            map_owner[i] = '0;
            map_stamp[i] = '0;
        end
        map_clock = '0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            issue_request(DIRECTED[r].req, DIRECTED[r].ident,
                          DIRECTED[r].typed, DIRECTED[r].want);
        end
        drain_results();

        for (int phase = 0; phase < PHASES; phase++) begin
            // Build a fresh identifier pool; pools with more distinct identifiers than the
            // 32 slots drive evictions, smaller ones exercise hits and releases.
            pool.delete();
            pool_size = $urandom_range(8, 64);
            for (int k = 0; k < pool_size; k++) begin
                case ($urandom_range(0, 11))
                    0:       pool.push_back(32'h0000_0000);
                    1:       pool.push_back(32'hFFFF_FFFF);
                    2:       pool.push_back(32'h8000_0000);
                    3:       pool.push_back(32'h7FFF_FFFF);
                    default: pool.push_back($urandom);
                endcase
            end
            // No idling at all in the closing phases; otherwise most phases idle.
            stall_enable <= (phase < PHASES - CALM_PHASES) && ($urandom_range(0, 3) != 0);

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < 68) begin
                    req   = REQ_ASSIGN;
                    ident = pool[$urandom_range(0, pool_size - 1)];
                end else if (roll < 88) begin
                    req   = REQ_RELEASE;
                    ident = pool[$urandom_range(0, pool_size - 1)];
                end else if (roll < 92) begin
                    req   = REQ_RELEASE;
                    ident = $urandom;
                end else if (roll < 97) begin
                    req   = REQ_ASSIGN;
                    ident = $urandom;
                end else if (roll < 99) begin
                    req   = REQ_UNUSED;
                    ident = $urandom;
                end else begin
                    req   = REQ_CLEAR;
                    ident = $urandom;
                end

                if (phase < PHASES - CALM_PHASES && stall_enable
                        && $urandom_range(0, 3) == 0) begin
                    hold_sender($urandom_range(1, 15));
                end
                issue_request(req, ident, 1'b0, '0);
            end
            // Let every result of the phase come home before the next pool.
            drain_results();
        end

        stall_enable <= 1'b0;
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
